// ----- design/resource_class_match_table_top_assert.svh -----
// Assertion macros used by the resource class match table top design file.
`ifndef RESOURCE_CLASS_MATCH_TABLE_TOP_ASSERT_SVH
`define RESOURCE_CLASS_MATCH_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCMT_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("resource class match table: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RCMT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("resource class match table: assertion failed");

`endif

// ----- design/rcmt_pkg.sv -----
`default_nettype none

package rcmt_pkg;

    localparam int COUNT_BITS = 12;
    localparam int SCORE_W    = 15;
    localparam int WINDOW_W   = 15;
    localparam int INDEX_W    = 4;
    localparam int STATUS_W   = 2;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(3);

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [SCORE_W-1:0]    score_t;
    typedef logic [WINDOW_W-1:0]   window_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_MATCHED = 2'd0,
        ST_CREATED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_REPLY
    } state_t;

    typedef struct packed {
        count_t uniform_count;
        count_t storage_count;
        count_t texel_count;
        count_t storage_texel_count;
        count_t sampled_image_count;
        count_t storage_image_count;
    } req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] class_index;
        status_t            status;
    } rsp_t;

    // One stored class: its six counts and its score.
    typedef struct packed {
        req_t   counts;
        score_t score;
    } row_t;

endpackage

`default_nettype wire

// ----- design/rcmt_match_unit.sv -----
`default_nettype none

module rcmt_match_unit (
    input  wire rcmt_pkg::req_t    req,
    input  wire rcmt_pkg::score_t  req_score,
    input  wire rcmt_pkg::row_t    row,
    input  wire rcmt_pkg::window_t window,
    output logic                   hit
);

    rcmt_pkg::score_t diff;
    logic             in_window;
    logic             covers;

    always_comb begin
        if (row.score >= req_score) begin
            diff = row.score - req_score;
        end else begin
            diff = req_score - row.score;
        end
        in_window = diff < window;
        covers = (row.counts.uniform_count       >= req.uniform_count)
              && (row.counts.storage_count       >= req.storage_count)
              && (row.counts.texel_count         >= req.texel_count)
              && (row.counts.storage_texel_count >= req.storage_texel_count)
              && (row.counts.sampled_image_count >= req.sampled_image_count)
              && (row.counts.storage_image_count >= req.storage_image_count);
        hit = in_window && covers;
    end

endmodule

`default_nettype wire

// ----- design/resource_class_match_table_top.sv -----
`default_nettype none

`include "resource_class_match_table_top_assert.svh"

// Resource class match table. Each item holds six resource counts; the block
// scans the stored classes in insertion order, one class per cycle through a
// single compare unit fed from a registered memory read, and returns the first
// class whose score lies strictly within score_window of the item's score and
// whose counts all cover the item's counts. On a miss the item is appended as
// a new class, or status reports a full table. Each scan makes one fetch ahead of
// the first compare and one compare per class tested (every stored class on a
// miss, fewer when a hit ends the scan early); the outcome is then held in a
// pending register and loaded into the result register once that is free. The
// next item can be taken as soon as the result appears, not before, so items do
// not overlap; a result that is not taken holds the next item's result and then
// the input. The table starts empty after reset and needs no clearing pass.
// score_window may be written at any time the block is idle; cfg_ready is always
// high.
module resource_class_match_table_top #(
    parameter int MAX_CLASSES = 16
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire rcmt_pkg::req_t    s_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output rcmt_pkg::rsp_t         m_data,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire rcmt_pkg::window_t cfg_wdata
);

    localparam int IDX_W     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CNT_W     = $clog2(MAX_CLASSES + 1);
    localparam int SCORE_W   = rcmt_pkg::SCORE_W;
    localparam int OUT_IDX_W = rcmt_pkg::INDEX_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CLASSES);

    rcmt_pkg::state_t  state_reg, state_next;
    rcmt_pkg::req_t    req_reg;
    rcmt_pkg::score_t  score_reg, score_next;
    rcmt_pkg::window_t window_reg;
    rcmt_pkg::row_t    rd_row_reg;
    rcmt_pkg::row_t    class_mem [MAX_CLASSES];

    logic [CNT_W-1:0]  entry_total_reg;
    logic [CNT_W-1:0]  fetch_idx_reg, fetch_idx_next;
    logic              test_vld_reg, test_vld_next;
    logic              test_last_reg, test_last_next;
    logic [IDX_W-1:0]  test_idx_reg;

    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    rcmt_pkg::status_t pend_status_reg, pend_status_next;

    logic              out_vld_reg, out_vld_next;
    logic [IDX_W-1:0]  out_idx_reg;
    rcmt_pkg::status_t out_status_reg;

    logic in_fire;
    logic out_free;
    logic searching;
    logic load_out;
    logic unit_hit;
    logic tbl_empty;
    logic tbl_full;
    logic fetch_more;
    logic srch_hit;
    logic srch_miss;

    rcmt_match_unit u_match (
        .req       (req_reg),
        .req_score (score_reg),
        .row       (rd_row_reg),
        .window    (window_reg),
        .hit       (unit_hit)
    );

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rcmt_pkg::S_IDLE: begin
                if (in_fire) begin
                    state_next = rcmt_pkg::S_SEARCH;
                end
            end
            rcmt_pkg::S_SEARCH: begin
                if (srch_hit || srch_miss) begin
                    state_next = rcmt_pkg::S_REPLY;
                end
            end
            rcmt_pkg::S_REPLY: begin
                if (out_free) begin
                    state_next = rcmt_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rcmt_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_ready   = 1'b0;
        searching = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            rcmt_pkg::S_IDLE: begin
                s_ready = 1'b1;
            end
            rcmt_pkg::S_SEARCH: begin
                searching = 1'b1;
            end
            rcmt_pkg::S_REPLY: begin
                load_out = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        in_fire    = s_valid && s_ready;
        out_free   = !out_vld_reg || m_ready;
        tbl_empty  = entry_total_reg == '0;
        tbl_full   = entry_total_reg == MAX_CNT;
        fetch_more = fetch_idx_reg < entry_total_reg;

        // A miss is known once the last stored class has been tested, or at once on an empty table.
        srch_hit  = searching && test_vld_reg && unit_hit;
        srch_miss = searching && !srch_hit
                 && (tbl_empty || (test_vld_reg && test_last_reg));

        score_next = SCORE_W'(s_data.uniform_count)
                   + SCORE_W'(s_data.storage_count)
                   + SCORE_W'(s_data.texel_count)
                   + SCORE_W'(s_data.storage_texel_count)
                   + SCORE_W'(s_data.sampled_image_count)
                   + SCORE_W'(s_data.storage_image_count);

        fetch_idx_next = fetch_idx_reg;
        test_vld_next  = 1'b0;
        test_last_next = 1'b0;
        if (in_fire) begin
            fetch_idx_next = '0;
        end else if (searching && fetch_more) begin
            fetch_idx_next = fetch_idx_reg + CNT_W'(1);
            test_vld_next  = 1'b1;
            test_last_next = (fetch_idx_reg + CNT_W'(1)) == entry_total_reg;
        end

        pend_idx_next    = pend_idx_reg;
        pend_status_next = pend_status_reg;
        if (srch_hit) begin
            pend_idx_next    = test_idx_reg;
            pend_status_next = rcmt_pkg::ST_MATCHED;
        end else if (srch_miss) begin
            if (tbl_full) begin
                pend_idx_next    = '0;
                pend_status_next = rcmt_pkg::ST_FULL;
            end else begin
                pend_idx_next    = entry_total_reg[IDX_W-1:0];
                pend_status_next = rcmt_pkg::ST_CREATED;
            end
        end

        out_vld_next = out_vld_reg;
        if (load_out) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= rcmt_pkg::S_IDLE;
            entry_total_reg <= '0;
            window_reg      <= rcmt_pkg::WINDOW_RESET;
            out_vld_reg     <= 1'b0;
            test_vld_reg    <= 1'b0;
            test_last_reg   <= 1'b0;
            fetch_idx_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            out_vld_reg   <= out_vld_next;
            test_vld_reg  <= test_vld_next;
            test_last_reg <= test_last_next;
            fetch_idx_reg <= fetch_idx_next;
            if (cfg_valid && cfg_ready) begin
                window_reg <= cfg_wdata;
            end
            if (srch_miss && !tbl_full) begin
                entry_total_reg <= entry_total_reg + CNT_W'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            req_reg   <= s_data;
            score_reg <= score_next;
        end
        test_idx_reg    <= fetch_idx_reg[IDX_W-1:0];
        pend_idx_reg    <= pend_idx_next;
        pend_status_reg <= pend_status_next;
        if (load_out) begin
            out_idx_reg    <= pend_idx_reg;
            out_status_reg <= pend_status_reg;
        end
    end

    // Class store: one write port for appends, one registered read port for the scan.
    always_ff @(posedge aclk) begin
        if (srch_miss && !tbl_full) begin
            class_mem[entry_total_reg[IDX_W-1:0]] <= '{counts: req_reg, score: score_reg};
        end
        rd_row_reg <= class_mem[fetch_idx_reg[IDX_W-1:0]];
    end

    always_comb begin
        cfg_ready          = 1'b1;
        m_valid            = out_vld_reg;
        m_data.class_index = OUT_IDX_W'(out_idx_reg);
        m_data.status      = out_status_reg;
    end

    `RCMT_ASSERT_SAME(a_total_bound, aclk, aresetn, 1'b1, entry_total_reg <= MAX_CNT)
    `RCMT_ASSERT_NEXT(a_create_grows, aclk, aresetn, aresetn && srch_miss && !tbl_full,
                      entry_total_reg == $past(entry_total_reg) + CNT_W'(1))
    `RCMT_ASSERT_SAME(a_full_status, aclk, aresetn,
                      out_vld_reg && out_status_reg == rcmt_pkg::ST_FULL, tbl_full)
    `RCMT_ASSERT_SAME(a_match_known, aclk, aresetn,
                      out_vld_reg && out_status_reg == rcmt_pkg::ST_MATCHED,
                      CNT_W'(out_idx_reg) < entry_total_reg)

endmodule

`default_nettype wire

// ----- tb/class_match_checker.sv -----
`timescale 1ns / 100ps

// Watches the request, reply and window channels of the class match table,
// keeps its own copy of the stored classes and checks every reply in order.
module class_match_checker
    import rcmt_pkg::*;
#(
    parameter int MAX_CLASSES = 16
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             s_valid,
    input  wire             s_ready,
    input  req_t            s_data,
    input  wire             m_valid,
    input  wire             m_ready,
    input  rsp_t            m_data,
    input  wire             cfg_valid,
    input  wire             cfg_ready,
    input  window_t         cfg_wdata,
    output int unsigned     outstanding,
    output int unsigned     mismatches
);

    window_t     window;
    int unsigned class_count;
    req_t        class_counts [MAX_CLASSES];
    int          class_score  [MAX_CLASSES];
    rsp_t        expected_replies [$];

    // First stored class within the window that covers every count wins;
    // otherwise the request becomes a new class if there is room.
    function automatic rsp_t lookup_or_insert(input req_t r);
        rsp_t reply;
        int   total;
        int   diff;
        int   hit;
        total = int'(r.uniform_count) + int'(r.storage_count) + int'(r.texel_count)
              + int'(r.storage_texel_count) + int'(r.sampled_image_count)
              + int'(r.storage_image_count);
        hit = -1;
        for (int i = 0; i < int'(class_count); i++) begin
            diff = (class_score[i] >= total) ? class_score[i] - total : total - class_score[i];
            if (hit < 0 && diff < int'(window)
                    && class_counts[i].uniform_count       >= r.uniform_count
                    && class_counts[i].storage_count       >= r.storage_count
                    && class_counts[i].texel_count         >= r.texel_count
                    && class_counts[i].storage_texel_count >= r.storage_texel_count
                    && class_counts[i].sampled_image_count >= r.sampled_image_count
                    && class_counts[i].storage_image_count >= r.storage_image_count) begin
                hit = i;
            end
        end
        if (hit >= 0) begin
            reply.class_index = INDEX_W'(hit);
            reply.status      = ST_MATCHED;
        end else if (class_count >= MAX_CLASSES) begin
            reply.class_index = '0;
            reply.status      = ST_FULL;
        end else begin
            class_counts[class_count] = r;
            class_score[class_count]  = total;
            reply.class_index         = INDEX_W'(class_count);
            reply.status              = ST_CREATED;
            class_count++;
        end
        return reply;
    endfunction

    always @(posedge aclk) begin
        rsp_t want;
        int   bad;
        bad = 0;
        if (!aresetn) begin
            window      = WINDOW_RESET;
            class_count = 0;
            expected_replies.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                window = cfg_wdata;
            end
            if (s_valid && s_ready) begin
                expected_replies.insert(expected_replies.size(), lookup_or_insert(s_data));
            end
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    $error("reply with no request waiting: class_index %0d, status %0d",
                           m_data.class_index, m_data.status);
                    bad++;
                end else begin
                    want = expected_replies.pop_front();
                    if (m_data.class_index !== want.class_index) begin
                        $error("class_index: expected %0d, actual %0d",
                               want.class_index, m_data.class_index);
                        bad++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_data.status);
                        bad++;
                    end
                end
            end
            outstanding <= expected_replies.size();
            mismatches  <= mismatches + bad;
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

    import rcmt_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 120;

    logic    aclk      = 1'b0;
    logic    aresetn   = 1'b0;
    logic    s_valid   = 1'b0;
    logic    s_ready;
    req_t    s_data    = '0;
    logic    m_valid;
    logic    m_ready   = 1'b0;
    rsp_t    m_data;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    window_t cfg_wdata = '0;

    int unsigned outstanding;
    int unsigned mismatches;
    int unsigned cycle_count = 0;

    // Traffic shaping shared between the request side and the reply side.
    logic        steady     = 1'b0;
    int unsigned hold_asked = 0;
    int unsigned hold_taken = 0;
    int          hold_left  = 0;

    // Requests already sent in the directed part; the random part derives
    // subsets of these so that most requests hit a stored class.
    req_t seeds [$];

    always #5 aclk = ~aclk;

    resource_class_match_table_top #(
        .MAX_CLASSES(TABLE_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_wdata(cfg_wdata)
    );

    class_match_checker #(
        .MAX_CLASSES(TABLE_DEPTH)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_wdata  (cfg_wdata),
        .outstanding(outstanding),
        .mismatches (mismatches)
    );

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_asked) begin
            m_ready    <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= hold_asked;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 37);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("resource_class_match_table_top test failed");
            $finish;
        end
    end

    task automatic send_request(input req_t r);
        int gap;
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        gap = 0;
        while (!steady && $urandom_range(0, 99) < 37) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_and_keep(input int u, input int s, input int t, input int st,
                                 input int si, input int sti);
        req_t r;
        r.uniform_count       = COUNT_BITS'(u);
        r.storage_count       = COUNT_BITS'(s);
        r.texel_count         = COUNT_BITS'(t);
        r.storage_texel_count = COUNT_BITS'(st);
        r.sampled_image_count = COUNT_BITS'(si);
        r.storage_image_count = COUNT_BITS'(sti);
        seeds.insert(seeds.size(), r);
        send_request(r);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_window(input window_t w);
        cfg_valid <= 1'b1;
        cfg_wdata <= w;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic req_t noise_request();
        req_t r;
        for (int k = 0; k < 6; k++) begin
            case ($urandom_range(0, 7))
                0:       r[k*COUNT_BITS +: COUNT_BITS] = '0;
                1:       r[k*COUNT_BITS +: COUNT_BITS] = '1;
                default: r[k*COUNT_BITS +: COUNT_BITS] = COUNT_BITS'($urandom_range(0, 4095));
            endcase
        end
        return r;
    endfunction

    // Lowers each count of a known class a little, keeping it covered.
    function automatic req_t shrink(input req_t seed, input int reach);
        req_t   r;
        count_t c;
        int     cut;
        for (int k = 0; k < 6; k++) begin
            c   = seed[k*COUNT_BITS +: COUNT_BITS];
            cut = $urandom_range(0, reach);
            r[k*COUNT_BITS +: COUNT_BITS] = (int'(c) > cut) ? c - COUNT_BITS'(cut) : '0;
        end
        return r;
    endfunction

    initial begin : stimulus
        req_t    r;
        req_t    seed;
        window_t w;
        int      kind;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset window of three: empty table, extremes, window edges.
        send_and_keep(0, 0, 0, 0, 0, 0);
        send_and_keep(0, 0, 0, 0, 0, 0);
        send_and_keep(4095, 4095, 4095, 4095, 4095, 4095);
        send_and_keep(4095, 4095, 4095, 4095, 4095, 4095);
        send_and_keep(1, 1, 1, 1, 1, 1);
        send_and_keep(1, 1, 1, 1, 1, 0);
        send_and_keep(1, 1, 1, 1, 0, 0);
        send_and_keep(1, 1, 1, 0, 0, 0);
        // Same score, but the storage image count is not covered.
        send_and_keep(10, 10, 10, 10, 10, 0);
        send_and_keep(10, 10, 10, 10, 9, 1);
        send_and_keep(9, 10, 10, 10, 11, 0);
        send_and_keep(10, 10, 10, 10, 10, 0);

        // A zero window never matches, so a duplicate becomes a new class.
        settle();
        write_window('0);
        send_and_keep(0, 0, 0, 0, 0, 0);

        // The widest window shows first-fit order among covering classes.
        settle();
        write_window('1);
        send_and_keep(0, 0, 0, 0, 0, 0);
        send_and_keep(4095, 0, 0, 0, 0, 0);

        // Fill the table and run past its end.
        settle();
        write_window('0);
        for (int n = 0; n < 10; n++) begin
            r = noise_request();
            seeds.insert(seeds.size(), r);
            send_request(r);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       w = WINDOW_RESET;
                1:       w = '0;
                2:       w = '1;
                3:       w = window_t'(1);
                4:       w = window_t'($urandom_range(4, 64));
                5:       w = window_t'(2);
                6:       w = window_t'($urandom_range(65, 32766));
                7:       w = window_t'(16);
                8:       w = window_t'(32766);
                9:       w = window_t'($urandom_range(0, 15));
                10:      w = window_t'(5);
                default: w = WINDOW_RESET;
            endcase
            settle();
            write_window(w);
            steady <= (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 5 && n == 10) begin
                    hold_asked <= hold_asked + 1;
                end
                if (phase == 7 && n == 60) begin
                    settle();
                end
                seed = seeds[$urandom_range(0, seeds.size() - 1)];
                kind = $urandom_range(0, 9);
                if (kind < 6) begin
                    r = shrink(seed, $urandom_range(0, 3));
                end else if (kind < 8) begin
                    // One kind asks for one slot more than the class holds.
                    r    = shrink(seed, 1);
                    kind = $urandom_range(0, 5);
                    if (seed[kind*COUNT_BITS +: COUNT_BITS] != '1) begin
                        r[kind*COUNT_BITS +: COUNT_BITS] =
                            seed[kind*COUNT_BITS +: COUNT_BITS] + 1'b1;
                    end
                end else begin
                    r = noise_request();
                end
                send_request(r);
            end
        end

        settle();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("resource_class_match_table_top test passed");
        end else begin
            $display("resource_class_match_table_top test failed");
        end
        $finish;
    end

endmodule
